// ===== src/cbc_pkg.sv =====
// shared types, constants and codes of the cartridge bank controller
package cbc_pkg;

  // sizing
  localparam int RAM_BANKS     = 4;
  localparam int BANK_BYTES    = 8192;
  localparam int ROM_BANK_BITS = 5;
  localparam int RAM_DEPTH     = RAM_BANKS * BANK_BYTES;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int ROM_AW        = 19;
  localparam int OFFSET_W      = $clog2(BANK_BYTES);
  localparam int CFG_IDX_W     = 8;

  // result kinds
  localparam logic [1:0] TGT_OPEN = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_TYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_CODE = 8'd1;

  // header cartridge types
  localparam logic [7:0] CART_MBC1      = 8'd1;
  localparam logic [7:0] CART_MBC1_BATT = 8'd3;

  // header ram codes
  localparam logic [7:0] RAM_CODE_ONE     = 8'd2;
  localparam logic [7:0] RAM_CODE_FOUR    = 8'd3;
  localparam logic [7:0] RAM_CODE_SIXTEEN = 8'd4;
  localparam logic [7:0] RAM_CODE_EIGHT   = 8'd5;

  // bus regions, address bits 15:13
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM  = 3'd5;

  // ram enable key in the low nibble
  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  // mapper state
  typedef struct packed {
    logic                     ram_enabled;
    logic [ROM_BANK_BITS-1:0] rom_bank;
    logic [1:0]               ram_bank_select;
    logic                     banking_mode;
    logic [1:0]               active_ram_bank;
    logic                     ram_dirty;
  } bank_state_t;

  // per access result, without ram data
  typedef struct packed {
    logic [1:0]        target;
    logic [ROM_AW-1:0] rom_address;
    logic              save_request;
    logic [1:0]        save_bank;
  } access_res_t;

  // banked ram request
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

// ===== src/cbc_ram.sv =====
// generic simple dual port ram with registered read
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, output holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cbc_decode.sv =====
// access decode: next mapper state, result kind and ram request for one access
module cbc_decode (
  input  cbc_pkg::bank_state_t st,
  input  logic [7:0]           hdr_type,
  input  logic [7:0]           hdr_ram_code,
  input  logic                 wr,
  input  logic [15:0]          addr,
  input  logic [7:0]           wdata,
  output cbc_pkg::bank_state_t st_nxt,
  output cbc_pkg::access_res_t res,
  output cbc_pkg::ram_req_t    req
);
  import cbc_pkg::*;

  logic                     mbc1;
  logic [2:0]               region;
  logic [4:0]               bank_limit;
  logic                     bank_ok;
  logic                     ram_ok;
  logic [ROM_BANK_BITS-1:0] rom_sel;

  assign mbc1   = hdr_type inside {[CART_MBC1:CART_MBC1_BATT]};
  assign region = addr[15:13];

  // number of banks the header grants
  always_comb begin
    case (hdr_ram_code)
      RAM_CODE_ONE:     bank_limit = 5'd1;
      RAM_CODE_FOUR:    bank_limit = 5'd4;
      RAM_CODE_SIXTEEN: bank_limit = 5'd16;
      RAM_CODE_EIGHT:   bank_limit = 5'd8;
      default:          bank_limit = 5'd0;
    endcase
  end

  assign bank_ok = ({3'b000, st.active_ram_bank} < bank_limit) &&
                   ({3'b000, st.active_ram_bank} < 5'(RAM_BANKS));
  assign ram_ok  = st.ram_enabled && bank_ok;
  assign rom_sel = wdata[ROM_BANK_BITS-1:0];

  // read mapping and register writes
  always_comb begin
    st_nxt           = st;
    res.target       = TGT_OPEN;
    res.rom_address  = '0;
    res.save_request = 1'b0;
    res.save_bank    = 2'd0;
    req.rd           = 1'b0;
    req.wr           = 1'b0;
    req.addr         = RAM_AW'({st.active_ram_bank, addr[OFFSET_W-1:0]});
    req.wdata        = wdata;

    if (!wr) begin
      if (!addr[15]) begin
        res.target = TGT_ROM;
        // fixed window, or switched window when mapped
        if (mbc1 && addr[14]) begin
          res.rom_address = ROM_AW'({st.rom_bank, addr[13:0]});
        end else begin
          res.rom_address = ROM_AW'(addr);
        end
      end else if (mbc1 && region == RGN_EXT_RAM && ram_ok) begin
        res.target = TGT_RAM;
        req.rd     = 1'b1;
      end
    end else if (mbc1) begin
      case (region)
        RGN_RAM_EN: begin
          st_nxt.ram_enabled = (wdata[3:0] == RAM_EN_KEY);
        end
        RGN_ROM_BANK: begin
          st_nxt.rom_bank = (rom_sel == '0) ? ROM_BANK_BITS'(1) : rom_sel;
        end
        RGN_RAM_BANK: begin
          st_nxt.ram_bank_select = wdata[1:0];
          if (st.banking_mode) begin
            st_nxt.active_ram_bank = wdata[1:0];
            res.save_request       = st.ram_dirty;
            res.save_bank          = st.ram_dirty ? st.active_ram_bank : 2'd0;
          end
        end
        RGN_MODE: begin
          st_nxt.banking_mode = wdata[0];
          if (wdata[0]) begin
            st_nxt.active_ram_bank = st.ram_bank_select;
            res.save_request       = st.ram_dirty;
            res.save_bank          = st.ram_dirty ? st.active_ram_bank : 2'd0;
          end
        end
        RGN_EXT_RAM: begin
          if (ram_ok) begin
            req.wr = 1'b1;
            if (hdr_type == CART_MBC1_BATT) begin
              st_nxt.ram_dirty = 1'b1;
            end
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

// ===== src/cartridge_bank_controller_top.sv =====
// top level of the cartridge bank controller
//
// Channels: in_* carries one bus access per transfer (tuser = write flag,
// tdata = address and write byte); out_* returns exactly one result per
// access (tuser = result kind, tdata = rom address, ram byte, save request
// and save bank); cfg_* writes the cartridge type (index 0) and the ram
// size code (index 1) and is always ready. Writes to other indexes are
// dropped. Configuration is meant to change only while no access is open.
// Pipeline: the decode result and the banked ram read are registered in the
// decode stage, then the result moves on into the output register.
// Throughput: one access per cycle while out_tready is high and no clearing
// pass runs, set by the single ram port pair and the two-stage pipeline.
// Reset: mapper state returns to its defaults and a clearing pass writes
// zero to all 32768 ram bytes, one byte per cycle; in_tready stays low until
// the pass ends. Configuration writes are taken during the pass.
// Stall: when out_tready is low the output register holds, the stage
// behind it fills, and then in_tready drops until the result is taken.
module cartridge_bank_controller_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input access
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,  // address[15:0], write_data[23:16]
  input  logic                          in_tuser,  // mode
  // result
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata, // rom_address[18:0], read_data[26:19],
                                                   // save_request[27], save_bank[29:28],
                                                   // zero[31:30]
  output logic [1:0]                    out_tuser, // target
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import cbc_pkg::*;

  logic              in_xfer;
  logic              advance;
  logic [7:0]        hdr_type_r;
  logic [7:0]        ram_code_r;
  bank_state_t       st_r;
  bank_state_t       st_nxt;
  access_res_t       acc_res;
  ram_req_t          acc_req;
  logic              clearing_r;
  logic [RAM_AW-1:0] clr_addr_r;
  logic              s1_valid_r;
  access_res_t       s1_res_r;
  logic              out_valid_r;
  access_res_t       out_res_r;
  logic [7:0]        out_rdata_r;
  logic [7:0]        ram_q;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_type_r <= 8'd0;
      ram_code_r <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HDR_TYPE) begin
        hdr_type_r <= cfg_data;
      end else if (cfg_index == CFG_RAM_CODE) begin
        ram_code_r <= cfg_data;
      end
    end
  end

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !clearing_r && (!s1_valid_r || advance);
  assign in_xfer   = in_tvalid && in_tready;

  cbc_decode u_decode (
    .st           (st_r),
    .hdr_type     (hdr_type_r),
    .hdr_ram_code (ram_code_r),
    .wr           (in_tuser),
    .addr         (in_tdata[15:0]),
    .wdata        (in_tdata[23:16]),
    .st_nxt       (st_nxt),
    .res          (acc_res),
    .req          (acc_req)
  );

  // mapper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ram_enabled     <= 1'b0;
      st_r.rom_bank        <= ROM_BANK_BITS'(1);
      st_r.ram_bank_select <= 2'd0;
      st_r.banking_mode    <= 1'b0;
      st_r.active_ram_bank <= 2'd0;
      st_r.ram_dirty       <= 1'b0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // ram write port shared by the clearing pass and bus writes
  assign ram_we    = clearing_r || (in_xfer && acc_req.wr);
  assign ram_waddr = clearing_r ? clr_addr_r : acc_req.addr;
  assign ram_wdata = clearing_r ? 8'd0 : acc_req.wdata;

  cbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer && acc_req.rd),
    .raddr (acc_req.addr),
    .rdata (ram_q)
  );

  // decode stage, ram data lands alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_res_r <= acc_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r   <= s1_res_r;
      out_rdata_r <= (s1_res_r.target == TGT_RAM) ? ram_q : OPEN_BUS;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {2'b00, out_res_r.save_bank, out_res_r.save_request,
                       out_rdata_r, out_res_r.rom_address};

endmodule

// ===== src/cbc_check.sv =====
// port-level checks of the cartridge bank controller, bound to the top level
module cbc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import cbc_pkg::*;

  // the clearing pass holds off accesses right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !in_tready)
    else $error("access taken during ram clearing");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // open bus and write-done results read 0xFF
  a_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == TGT_OPEN |-> out_tdata[26:19] == OPEN_BUS)
    else $error("open bus data is not 0xFF");

  // rom address only on rom fetches
  a_rom_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != TGT_ROM |-> out_tdata[18:0] == '0)
    else $error("rom address on a non-rom result");

  // save bank is only reported with a save request
  a_save_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[27] |-> out_tdata[29:28] == 2'd0)
    else $error("save bank without save request");

endmodule

bind cartridge_bank_controller_top cbc_check u_check (.*);

// ===== dv/tb.sv =====
// self-checking testbench of the cartridge bank controller top level
module tb;
  import cbc_pkg::*;

  // access kinds on in_tuser
  localparam logic BUS_RD = 1'b0;
  localparam logic BUS_WR = 1'b1;

  localparam int LATENCY     = 2;
  localparam int N_PHASE     = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int LONG_HOLD   = 500;
  localparam int MAX_PRINT   = 40;

  // one result as the block returns it
  typedef struct packed {
    logic [1:0]        target;
    logic [ROM_AW-1:0] rom_address;
    logic [7:0]        read_data;
    logic              save_request;
    logic [1:0]        save_bank;
  } bus_result_t;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

  // directed row; a register row carries its index in addr
  typedef struct {
    row_kind_t   kind;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          typed;
    bus_result_t want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // mapper image kept by the testbench
  logic [7:0]               hdr_type_q = '0;
  logic [7:0]               ram_code_q = '0;
  logic                     ram_on = 1'b0;
  logic [ROM_BANK_BITS-1:0] rom_sel = ROM_BANK_BITS'(1);
  logic [1:0]               ram_sel = '0;
  logic                     mode_sel = 1'b0;
  logic [1:0]               ram_cur = '0;
  logic                     ram_touched = 1'b0;
  logic [7:0]               ram_img [RAM_DEPTH];

  bus_result_t pending_results [$];
  plan_row_t   plan [$];

  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int save_seen = 0;
  int reg_writes = 0;
  bit src_pace = 1'b1;
  bit sink_pace = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  cartridge_bank_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // address[15:0], write_data[23:16]
    .in_tuser   (in_tuser),   // mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // rom_address[18:0], read_data[26:19], save_request[27],
                              // save_bank[29:28]
    .out_tuser  (out_tuser),  // target
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    #(64'd12_000_000);
    $display("watchdog expired with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_error(string what, longint got_v, longint want_v);
    err_count++;
    if (err_count <= MAX_PRINT)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got_v, want_v);
  endtask

  // ram bank presence for the current size code
  function automatic bit bank_present(logic [1:0] b);
    int lim;
    case (ram_code_q)
      RAM_CODE_ONE:     lim = 1;
      RAM_CODE_FOUR:    lim = 4;
      RAM_CODE_SIXTEEN: lim = 16;
      RAM_CODE_EIGHT:   lim = 8;
      default:          lim = 0;
    endcase
    return (int'(b) < lim) && (int'(b) < RAM_BANKS);
  endfunction

  // make the selected ram bank current, asking for a save when dirty
  function automatic void swap_ram_bank(inout bus_result_t r);
    if (ram_touched) begin
      r.save_request = 1'b1;
      r.save_bank    = ram_cur;
    end
    ram_cur = ram_sel;
  endfunction

  // result of one bus access, advancing the mapper image
  function automatic bus_result_t bank_access_result(logic wr, logic [15:0] a,
                                                     logic [7:0] d);
    bus_result_t              r;
    logic [2:0]               rgn;
    logic [OFFSET_W-1:0]      off;
    logic [1:0]               bk;
    logic [ROM_BANK_BITS-1:0] nb;
    bit                       mapped;
    r      = '{target: TGT_OPEN, rom_address: '0, read_data: OPEN_BUS,
               save_request: 1'b0, save_bank: 2'd0};
    rgn    = a[15:13];
    off    = a[OFFSET_W-1:0];
    bk     = ram_cur;
    mapped = (hdr_type_q >= CART_MBC1) && (hdr_type_q <= CART_MBC1_BATT);
    if (wr == BUS_RD) begin
      if (!mapped) begin
        if (a < 16'h8000) begin
          r.target      = TGT_ROM;
          r.rom_address = ROM_AW'(a);
        end
      end else if (a < 16'h4000) begin
        r.target      = TGT_ROM;
        r.rom_address = ROM_AW'(a);
      end else if (a < 16'h8000) begin
        // switched window: bank in the top bits, window offset below
        r.target      = TGT_ROM;
        r.rom_address = {rom_sel, a[13:0]};
      end else if (rgn == RGN_EXT_RAM && ram_on && bank_present(bk)) begin
        r.target    = TGT_RAM;
        r.read_data = ram_img[{bk, off}];
      end
      return r;
    end
    if (!mapped) return r;
    case (rgn)
      RGN_RAM_EN: ram_on = (d[3:0] == RAM_EN_KEY);
      RGN_ROM_BANK: begin
        nb = d[ROM_BANK_BITS-1:0];
        rom_sel = (nb == '0) ? ROM_BANK_BITS'(1) : nb;
      end
      RGN_RAM_BANK: begin
        ram_sel = d[1:0];
        if (mode_sel) swap_ram_bank(r);
      end
      RGN_MODE: begin
        mode_sel = d[0];
        if (mode_sel) swap_ram_bank(r);
      end
      RGN_EXT_RAM: begin
        if (ram_on && bank_present(bk)) begin
          ram_img[{bk, off}] = d;
          if (hdr_type_q == CART_MBC1_BATT) ram_touched = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // directed row builders
  function automatic void acc(logic wr, logic [15:0] a, logic [7:0] d);
    plan.push_back('{kind: ROW_ACCESS, wr: wr, addr: a, data: d, typed: 1'b0, want: '0});
  endfunction

  function automatic void acc_want(logic wr, logic [15:0] a, logic [7:0] d, logic [1:0] tgt,
                                   logic [ROM_AW-1:0] ra, logic [7:0] rd, logic sr,
                                   logic [1:0] sb);
    plan.push_back('{kind: ROW_ACCESS, wr: wr, addr: a, data: d, typed: 1'b1,
                     want: '{target: tgt, rom_address: ra, read_data: rd,
                             save_request: sr, save_bank: sb}});
  endfunction

  function automatic void reg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    plan.push_back('{kind: ROW_REG, wr: BUS_RD, addr: 16'(idx), data: v, typed: 1'b0,
                     want: '0});
  endfunction

  function automatic int gap_len(bit pace);
    int r;
    if (!pace) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one access on the input channel; valid stays up after the transfer
  task automatic send_access(logic wr, logic [15:0] a, logic [7:0] d, bit typed,
                             bus_result_t want);
    int          gap;
    bus_result_t p;
    gap = gap_len(src_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= wr;
    in_tdata  <= {d, a};
    do @(posedge clk); while (!in_tready);
    p = bank_access_result(wr, a, d);
    pending_results.push_back(typed ? want : p);
    sent_count++;
  endtask

  // register write once every access has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_HDR_TYPE) hdr_type_q = v;
    else if (idx == CFG_RAM_CODE) ram_code_q = v;
    reg_writes++;
  endtask

  // random access, mostly well-formed mapper traffic
  task automatic pick_access(output logic wr, output logic [15:0] a, output logic [7:0] d);
    int                  k;
    logic [OFFSET_W-1:0] off;
    k   = $urandom_range(0, 99);
    d   = 8'($urandom);
    off = ($urandom_range(0, 1) == 0) ? OFFSET_W'($urandom)
        : {($urandom_range(0, 1) == 0) ? 7'h00 : 7'h7F, 6'($urandom)};
    if (k < 10) begin
      wr = 1'($urandom);
      a  = 16'($urandom);
    end else if (k < 20) begin
      wr = BUS_WR;
      a  = {RGN_RAM_EN, 13'($urandom)};
      if ($urandom_range(0, 9) < 7) d[3:0] = RAM_EN_KEY;
    end else if (k < 30) begin
      wr = BUS_WR;
      a  = {RGN_ROM_BANK, 13'($urandom)};
    end else if (k < 38) begin
      wr = BUS_WR;
      a  = {RGN_RAM_BANK, 13'($urandom)};
    end else if (k < 45) begin
      wr = BUS_WR;
      a  = {RGN_MODE, 13'($urandom)};
    end else if (k < 60) begin
      wr = BUS_RD;
      a  = 16'($urandom_range(0, 16'h7FFF));
    end else if (k < 85) begin
      wr = BUS_WR;
      a  = {RGN_EXT_RAM, off};
    end else begin
      wr = BUS_RD;
      a  = {RGN_EXT_RAM, off};
    end
  endtask

  // output ready pacing, with one long hold-off on request
  initial begin : sink_pacing
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (idle_left == 0 && long_hold_req && !long_hold_done) begin
        idle_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (idle_left == 0 && sink_pace && $urandom_range(0, 99) < 20) begin
        idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 50)
                                                : $urandom_range(1, 3);
      end
      if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : result_check
    bus_result_t want;
    bus_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.target       = out_tuser;
      got.rom_address  = out_tdata[18:0];
      got.read_data    = out_tdata[26:19];
      got.save_request = out_tdata[27];
      got.save_bank    = out_tdata[29:28];
      if (got.save_request) save_seen++;
      if (pending_results.size() == 0) begin
        flag_error("unexpected result transfer", longint'(got), 0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.target !== want.target)
          flag_error("target", got.target, want.target);
        if (got.rom_address !== want.rom_address)
          flag_error("rom_address", got.rom_address, want.rom_address);
        if (got.read_data !== want.read_data)
          flag_error("read_data", got.read_data, want.read_data);
        if (got.save_request !== want.save_request)
          flag_error("save_request", got.save_request, want.save_request);
        if (got.save_bank !== want.save_bank)
          flag_error("save_bank", got.save_bank, want.save_bank);
        if (out_tdata[31:30] !== 2'b00)
          flag_error("tdata padding", out_tdata[31:30], 0);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  phase_type [N_PHASE];
    logic [7:0]  phase_code [N_PHASE];
    foreach (ram_img[i]) ram_img[i] = 8'h00;
    phase_type = '{CART_MBC1_BATT, CART_MBC1, 8'd0, CART_MBC1_BATT, 8'd255, 8'd2,
                   8'($urandom), CART_MBC1_BATT};
    phase_code = '{RAM_CODE_FOUR, RAM_CODE_ONE, 8'd0, RAM_CODE_SIXTEEN, 8'd255,
                   RAM_CODE_EIGHT, 8'($urandom), RAM_CODE_FOUR};

    // directed: plain passthrough after reset, then battery mbc1 with four banks
    acc_want(BUS_RD, 16'h0000, 8'h00, TGT_ROM, 19'h00000, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_RD, 16'h7FFF, 8'hFF, TGT_ROM, 19'h07FFF, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_RD, 16'h8000, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_WR, 16'h0000, 8'h0A, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_RD, 16'hA000, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    reg_row(CFG_HDR_TYPE, CART_MBC1_BATT);
    reg_row(CFG_RAM_CODE, RAM_CODE_FOUR);
    acc_want(BUS_RD, 16'h3FFF, 8'h00, TGT_ROM, 19'h03FFF, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_RD, 16'h4000, 8'h00, TGT_ROM, 19'h04000, OPEN_BUS, 1'b0, 2'd0);
    // bank zero and bank with only unused bits set both map to bank one
    acc_want(BUS_WR, 16'h2000, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc(BUS_WR, 16'h2ABC, 8'hE0);
    acc_want(BUS_RD, 16'h7FFF, 8'h00, TGT_ROM, 19'h07FFF, OPEN_BUS, 1'b0, 2'd0);
    acc(BUS_WR, 16'h3FFF, 8'hFF);
    acc_want(BUS_RD, 16'h7FFF, 8'h00, TGT_ROM, 19'h7FFFF, OPEN_BUS, 1'b0, 2'd0);
    // ram disabled, then enabled through the low nibble key
    acc_want(BUS_RD, 16'hA000, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc(BUS_WR, 16'h1FFF, 8'h3A);
    acc_want(BUS_RD, 16'hBFFF, 8'h00, TGT_RAM, 19'h0, 8'h00, 1'b0, 2'd0);
    acc(BUS_WR, 16'hA000, 8'hA5);
    acc_want(BUS_RD, 16'hA000, 8'h00, TGT_RAM, 19'h0, 8'hA5, 1'b0, 2'd0);
    // bank switches while dirty
    acc(BUS_WR, 16'h5FFF, 8'h03);
    acc_want(BUS_WR, 16'h6000, 8'h01, TGT_OPEN, 19'h0, OPEN_BUS, 1'b1, 2'd0);
    acc(BUS_WR, 16'hA000, 8'h5A);
    acc(BUS_RD, 16'hA000, 8'h00);
    acc_want(BUS_WR, 16'h4000, 8'h02, TGT_OPEN, 19'h0, OPEN_BUS, 1'b1, 2'd3);
    // unmapped ranges
    acc_want(BUS_WR, 16'h8000, 8'h12, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_WR, 16'hC000, 8'h34, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc_want(BUS_RD, 16'hFFFF, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);
    acc(BUS_WR, 16'h0000, 8'h0B);
    acc_want(BUS_RD, 16'hA000, 8'h00, TGT_OPEN, 19'h0, OPEN_BUS, 1'b0, 2'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG)
        write_reg(CFG_IDX_W'(plan[i].addr), plan[i].data);
      else
        send_access(plan[i].wr, plan[i].addr, plan[i].data, plan[i].typed, plan[i].want);
    end

    // random phases over a spread of cartridge settings
    for (int ph = 0; ph < N_PHASE; ph++) begin
      write_reg(CFG_HDR_TYPE, phase_type[ph]);
      write_reg(CFG_RAM_CODE, phase_code[ph]);
      write_reg(CFG_IDX_W'($urandom_range(2, 255)), 8'($urandom));
      src_pace  = (ph % 3 != 2) && (ph != N_PHASE - 1);
      sink_pace = (ph % 4 != 3) && (ph != N_PHASE - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) long_hold_req = 1'b1;
        pick_access(wr, a, d);
        send_access(wr, a, d, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    // drain and let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d accesses, %0d results checked, %0d register writes",
             sent_count, checked_count, reg_writes);
    $display("save requests seen: %0d, mismatches: %0d", save_seen, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
